@@ src/sioe_pkg.sv @@
// Package for the square image orientation engine: types, codes and address remapping.
package sioe_pkg;

    // Image geometry
    localparam int SIZE  = 16;
    localparam int IDX_W = (SIZE > 1) ? $clog2(SIZE) : 1;

    // Request function codes
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_XFORM = 2'd2;

    // Transform codes
    localparam logic [2:0] OP_FLIP_H    = 3'd0;
    localparam logic [2:0] OP_FLIP_V    = 3'd1;
    localparam logic [2:0] OP_ROT_CW    = 3'd2;
    localparam logic [2:0] OP_ROT_CCW   = 3'd3;
    localparam logic [2:0] OP_TRANSPOSE = 3'd4;

    typedef logic [IDX_W-1:0] t_idx;

    typedef struct packed {
        logic [1:0] func;
        logic [3:0] row;
        logic [3:0] col;
        logic [7:0] pixel_in;
        logic [2:0] op;
    } t_req;

    typedef struct packed {
        logic [7:0] pixel_out;
    } t_rsp;

    // Orientation: logical (r, c) swaps to (a, b) if swap, then each axis may mirror
    typedef struct packed {
        logic swap;
        logic flip_r;
        logic flip_c;
    } t_orient;

    typedef struct packed {
        t_idx pr;
        t_idx pc;
    } t_loc;

    // Mirror one index within the image
    function automatic t_idx mirror_idx(input t_idx x);
        return IDX_W'(SIZE - 1) - x;
    endfunction

    // Horizontal flip acts on the current orientation
    function automatic t_orient flip_h(input t_orient o);
        t_orient n;
        n = o;
        if (o.swap) n.flip_r = ~o.flip_r;
        else        n.flip_c = ~o.flip_c;
        return n;
    endfunction

    // Vertical flip acts on the current orientation
    function automatic t_orient flip_v(input t_orient o);
        t_orient n;
        n = o;
        if (o.swap) n.flip_c = ~o.flip_c;
        else        n.flip_r = ~o.flip_r;
        return n;
    endfunction

    // Compose one transform onto the orientation; unused codes keep it
    function automatic t_orient compose_orient(input t_orient o, input logic [2:0] op);
        t_orient t;
        t = o;
        t.swap = ~o.swap;
        case (op)
            OP_FLIP_H:    return flip_h(o);
            OP_FLIP_V:    return flip_v(o);
            OP_ROT_CW:    return flip_h(t);
            OP_ROT_CCW:   return flip_v(t);
            OP_TRANSPOSE: return t;
            default:      return o;
        endcase
    endfunction

    // Map a logical pixel position to its physical place in the store
    function automatic t_loc remap(input t_orient o, input t_idx r, input t_idx c);
        t_idx a;
        t_idx b;
        t_loc l;
        a = o.swap ? c : r;
        b = o.swap ? r : c;
        l.pr = o.flip_r ? mirror_idx(a) : a;
        l.pc = o.flip_c ? mirror_idx(b) : b;
        return l;
    endfunction

endpackage

@@ src/sioe_if.sv @@
// Request and response stream interfaces of the orientation engine.
interface sioe_req_if;
    import sioe_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sioe_rsp_if;
    import sioe_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/square_image_orientation_engine_core.sv @@
// A read response is loaded in the response step after the remap and store access steps.
// One request at a time: the next request is taken only after a transform leaves the shared
// address remap step, a write leaves the store access and a read loads its response.
// A read waits in its last step while an earlier response is not yet taken.
// Reset: orientation returns to identity and the response register empties;
// pixel contents stay undefined until written.
module square_image_orientation_engine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sioe_req_if.sink    i_req,
    sioe_rsp_if.source  o_rsp
);
    import sioe_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAP,
        S_ACCESS,
        S_LOAD
    } t_state;

    t_state     r_state;
    t_orient    r_orient;
    logic [1:0] r_func;
    logic [2:0] r_op;
    logic [3:0] r_row;
    logic [3:0] r_col;
    logic [7:0] r_pix;
    t_idx       r_pr;
    t_idx       r_pc;
    logic       r_inside;
    logic       r_out_valid;
    logic [7:0] r_out_data;
    logic [7:0] r_rd_data;

    logic [7:0] mem [SIZE][SIZE];

    t_loc       n_loc;
    logic       n_inside;
    logic       wr_en;
    logic       rsp_free;
    logic       rsp_load;

    // Remap the held position through the current orientation
    always_comb begin
        n_loc    = remap(r_orient, IDX_W'(r_row), IDX_W'(r_col));
        n_inside = (32'(r_row) < SIZE) && (32'(r_col) < SIZE);
    end

    assign wr_en    = (r_state == S_ACCESS) && (r_func == FUNC_WRITE) && r_inside;
    assign rsp_free = !r_out_valid || o_rsp.ready;
    assign rsp_load = (r_state == S_LOAD) && rsp_free;

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.data.pixel_out = r_out_data;

    // Sequence one request through remap, store access and response load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_orient    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Load a new response or drop the one just taken
            if (rsp_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_func  <= i_req.data.func;
                        r_op    <= i_req.data.op;
                        r_row   <= i_req.data.row;
                        r_col   <= i_req.data.col;
                        r_pix   <= i_req.data.pixel_in;
                        r_state <= S_MAP;
                    end
                end
                S_MAP: begin
                    r_pr     <= n_loc.pr;
                    r_pc     <= n_loc.pc;
                    r_inside <= n_inside;
                    if (r_func == FUNC_XFORM) begin
                        r_orient <= compose_orient(r_orient, r_op);
                        r_state  <= S_IDLE;
                    end else if (r_func == FUNC_WRITE || r_func == FUNC_READ) begin
                        r_state <= S_ACCESS;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_ACCESS: begin
                    r_state <= (r_func == FUNC_READ) ? S_LOAD : S_IDLE;
                end
                S_LOAD: begin
                    if (rsp_load) begin
                        r_out_data  <= r_inside ? r_rd_data : 8'd0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Image store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_pr][r_pc] <= r_pix;
        end
        r_rd_data <= mem[r_pr][r_pc];
    end

    // An accepted read reaches the response step after the remap and store access steps
    a_read_reaches_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && i_req.data.func == FUNC_READ)
            |-> ##3 (r_state == S_LOAD))
        else $error("read request did not reach response step");

    // Only reads ever wait to load a response
    a_load_only_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> (r_func == FUNC_READ))
        else $error("non-read request in response step");

    // Orientation changes only when a transform passes the remap step
    a_orient_only_xform: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_orient))
            |-> ($past(r_state) == S_MAP && $past(r_func) == FUNC_XFORM))
        else $error("orientation changed outside a transform");

endmodule

@@ bench/tb.sv @@
// Testbench for the orientation engine: random pixel writes, reads and transforms against a shadow image.
module tb;
    import sioe_pkg::*;

    // Spare function code that the block ignores
    localparam logic [1:0] FUNC_SPARE = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int RANDOM_REQS = 600;

    // One image cell: bit 8 marks a written pixel, bits 7:0 hold its value
    typedef logic [8:0] t_plane [SIZE][SIZE];

    typedef struct {
        t_req req;
        bit   drain;
    } t_pending;

    logic i_clk;
    logic i_rst_n;

    sioe_req_if req_ch ();
    sioe_rsp_if rsp_ch ();

    square_image_orientation_engine_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    t_pending    req_backlog[$];
    logic [7:0]  pixels_due[$];
    t_plane      gen_plane;
    t_plane      shadow_plane;
    int unsigned reqs_taken;
    int unsigned reqs_issued;
    int unsigned cycles;
    int unsigned faults;
    int          hold_left;
    bit          hold_done;

    // Clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Rebuild the image after one transform; unused codes keep it as is
    function automatic t_plane reoriented(t_plane p, logic [2:0] op);
        t_plane n;
        for (int r = 0; r < SIZE; r++) begin
            for (int c = 0; c < SIZE; c++) begin
                case (op)
                    OP_FLIP_H:    n[r][c] = p[r][SIZE-1-c];
                    OP_FLIP_V:    n[r][c] = p[SIZE-1-r][c];
                    OP_ROT_CW:    n[r][c] = p[SIZE-1-c][r];
                    OP_ROT_CCW:   n[r][c] = p[c][SIZE-1-r];
                    OP_TRANSPOSE: n[r][c] = p[c][r];
                    default:      n[r][c] = p[r][c];
                endcase
            end
        end
        return n;
    endfunction

    task automatic report_fault(string msg);
        $display("cycle %0d: %s", cycles, msg);
        faults++;
    endtask

    // Advance the shadow image by one accepted request
    task automatic track_request(t_req q);
        bit in_range;
        in_range = (q.row < SIZE) && (q.col < SIZE);
        case (q.func)
            FUNC_WRITE: begin
                if (in_range) shadow_plane[q.row][q.col] = {1'b1, q.pixel_in};
            end
            FUNC_READ: begin
                pixels_due.push_back(in_range ? shadow_plane[q.row][q.col][7:0] : 8'd0);
            end
            FUNC_XFORM: begin
                shadow_plane = reoriented(shadow_plane, q.op);
            end
            default: ;
        endcase
    endtask

    // Queue one request and keep track of which pixels it leaves written
    task automatic add_req(logic [1:0] f, logic [3:0] r, logic [3:0] c,
                           logic [7:0] px, logic [2:0] o, bit drain);
        t_pending p;
        p.req.func     = f;
        p.req.row      = r;
        p.req.col      = c;
        p.req.pixel_in = px;
        p.req.op       = o;
        p.drain        = drain;
        req_backlog.push_back(p);
        if (f == FUNC_WRITE) gen_plane[r][c] = {1'b1, px};
        else if (f == FUNC_XFORM) gen_plane = reoriented(gen_plane, o);
    endtask

    // Build one random request; reads only target pixels already written
    task automatic add_random_req(int idx);
        int          pick;
        logic [3:0]  r;
        logic [3:0]  c;
        logic [7:0]  px;
        logic [2:0]  o;
        logic [1:0]  f;
        pick = $urandom_range(0, 99);
        r    = 4'($urandom);
        c    = 4'($urandom);
        px   = 8'($urandom);
        o    = 3'($urandom);
        if (idx < 40 || pick < 38) begin
            f = FUNC_WRITE;
        end else if (pick < 75) begin
            f = FUNC_READ;
            while (!gen_plane[r][c][8]) begin
                r = 4'($urandom);
                c = 4'($urandom);
            end
        end else if (pick < 93) begin
            f = FUNC_XFORM;
            o = ($urandom_range(0, 99) < 88) ? 3'($urandom_range(0, 4))
                                             : 3'($urandom_range(5, 7));
        end else begin
            f = FUNC_SPARE;
        end
        add_req(f, r, c, px, o, idx == 150 || idx == 350);
    endtask

    // Stimulus, reset and end of run
    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;
        reqs_taken   = 0;
        reqs_issued  = 0;
        cycles       = 0;
        faults       = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        for (int r = 0; r < SIZE; r++) begin
            for (int c = 0; c < SIZE; c++) begin
                gen_plane[r][c]    = '0;
                shadow_plane[r][c] = '0;
            end
        end

        // Corners with extreme values, ignored function, every transform
        add_req(FUNC_WRITE, 4'd0, 4'd0, 8'h00, OP_FLIP_H, 1'b0);
        add_req(FUNC_WRITE, 4'd0, 4'd15, 8'hFF, 3'd7, 1'b0);
        add_req(FUNC_WRITE, 4'd15, 4'd0, 8'hA5, OP_TRANSPOSE, 1'b0);
        add_req(FUNC_WRITE, 4'd15, 4'd15, 8'h5A, OP_ROT_CW, 1'b0);
        add_req(FUNC_SPARE, 4'd15, 4'd15, 8'hFF, 3'd7, 1'b0);
        for (int k = 0; k < 8; k++) begin
            add_req(FUNC_XFORM, 4'($urandom), 4'($urandom), 8'($urandom), 3'(k), 1'b0);
            add_req(FUNC_READ, k[1] ? 4'd15 : 4'd0, k[0] ? 4'd15 : 4'd0,
                    8'($urandom), 3'($urandom), 1'b0);
        end
        for (int k = 0; k < 4; k++) begin
            add_req(FUNC_READ, k[1] ? 4'd15 : 4'd0, k[0] ? 4'd15 : 4'd0,
                    8'($urandom), 3'($urandom), 1'b0);
        end

        for (int i = 0; i < RANDOM_REQS; i++) add_random_req(i);

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: nothing left to send and nothing left to receive
        while (req_backlog.size() != 0 || req_ch.valid || pixels_due.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (faults == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Request driver: hold the request until taken, then offer the next one
    always @(negedge i_clk) begin
        bit calm;
        bit busy;
        calm = (reqs_taken >= 200) && (reqs_taken < 320);
        busy = req_ch.valid && (reqs_taken != reqs_issued);
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!busy) begin
            if (req_backlog.size() != 0
                && !(req_backlog[0].drain && pixels_due.size() != 0)
                && (calm || $urandom_range(0, 99) >= 14)) begin
                req_ch.valid <= 1'b1;
                req_ch.data  <= req_backlog[0].req;
                void'(req_backlog.pop_front());
                reqs_issued++;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Response sink: random stalls plus one long hold-off
    always @(negedge i_clk) begin
        bit calm;
        calm = (reqs_taken >= 200) && (reqs_taken < 320);
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (!hold_done && reqs_taken >= 450) begin
            rsp_ch.ready <= 1'b0;
            hold_done    <= 1'b1;
            hold_left    <= 80;
        end else begin
            rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 14);
        end
    end

    // Monitor: predict on accepted requests, check accepted responses
    always @(posedge i_clk) begin
        logic [7:0] want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (pixels_due.size() == 0) begin
                    report_fault($sformatf("unexpected response pixel_out=%0h",
                                           rsp_ch.data.pixel_out));
                end else begin
                    want = pixels_due.pop_front();
                    if (rsp_ch.data.pixel_out !== want)
                        report_fault($sformatf("pixel_out got %0h want %0h",
                                               rsp_ch.data.pixel_out, want));
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                track_request(req_ch.data);
                reqs_taken++;
            end
        end
    end

endmodule

@@ filelist.f @@
src/sioe_pkg.sv
src/sioe_if.sv
src/square_image_orientation_engine_core.sv
bench/tb.sv
